// ===== src/wrtp_pkg.sv =====
// Package for the weighted random tile pick block: payload structs, chain control structs,
// field widths and default parameter values. It depends on nothing else.
package wrtp_pkg;

   localparam int unsigned MAX_ENTRIES = 16;
   localparam int unsigned WEIGHT_BITS = 8;
   localparam int unsigned RANDOM_BITS = 16;

   localparam int unsigned INDEX_BITS        = 4;
   localparam int unsigned TYPE_BITS         = 4;
   localparam int unsigned FIELD_WEIGHT_BITS = 8;
   localparam int unsigned FIELD_RANDOM_BITS = 16;
   localparam int unsigned CNT_BITS          = 5;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PICK  = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic [INDEX_BITS-1:0]        entry_index;
      logic [TYPE_BITS-1:0]         entry_type;
      logic [FIELD_WEIGHT_BITS-1:0] entry_weight;
      logic [TYPE_BITS-1:0]         query_type;
      logic [FIELD_RANDOM_BITS-1:0] random_value;
   } wrtp_req_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] picked_index;
   } wrtp_rsp_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                         wr_en;
      logic [INDEX_BITS-1:0]        wr_index;
      logic [TYPE_BITS-1:0]         wr_type;
      logic [FIELD_WEIGHT_BITS-1:0] wr_weight;
      logic [TYPE_BITS-1:0]         query_type;
      logic [CNT_BITS-1:0]          tile_count;
      logic                         pass2;
   } wrtp_cmd_type;

   // Control part of the token that walks down the chain.
   typedef struct packed {
      logic valid;
      logic any;
      logic hit;
   } wrtp_tok_type;

endpackage

// ===== src/weighted_random_tile_pick.sv =====
// Weighted random tile pick: a write item updates one table entry and yields no result. Depends on
// wrtp_pkg and wrtp_cell. A pick sends a token twice down a chain of MAX_ENTRIES cells, one
// cell per cycle: the first pass sums the weights, the second finds the entry. The second pass
// is skipped with no match or zero total weight. No new item is taken until the result has been
// registered in the output register, which waits while an older result is still stalled.
// Synchronous active-high reset clears the table, the tile count and all control state.
module weighted_random_tile_pick #(
   parameter int unsigned MAX_ENTRIES = wrtp_pkg::MAX_ENTRIES,
   parameter int unsigned WEIGHT_BITS = wrtp_pkg::WEIGHT_BITS,
   parameter int unsigned RANDOM_BITS = wrtp_pkg::RANDOM_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wrtp_pkg::wrtp_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wrtp_pkg::wrtp_rsp_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [wrtp_pkg::CNT_BITS-1:0] csr_wr_data
);

   localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
   localparam int unsigned SUM_W  = WEIGHT_BITS + IDX_W;
   localparam int unsigned THR_W  = SUM_W + RANDOM_BITS;
   localparam int unsigned PROD_W = THR_W + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic                            inject_ff, inject_in;
   logic                            pass2_ff, pass2_in;
   logic [wrtp_pkg::TYPE_BITS-1:0]  qtype_ff, qtype_in;
   logic [RANDOM_BITS-1:0]          rnd_ff, rnd_in;
   logic [wrtp_pkg::CNT_BITS-1:0]   tile_ff, tile_in;
   logic [SUM_W-1:0]                total_ff, total_in;
   logic [IDX_W-1:0]                last_ff, last_in;
   logic                            found_ff, found_in;
   logic [IDX_W-1:0]                pick_ff, pick_in;
   logic [THR_W-1:0]                thr_ff, thr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   wrtp_pkg::wrtp_rsp_type          rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic [RANDOM_BITS:0]            rnd_p1;
   logic [PROD_W-1:0]               prod;
   wrtp_pkg::wrtp_cmd_type          cmd;

   wrtp_pkg::wrtp_tok_type chain_tok [MAX_ENTRIES+1];
   logic [SUM_W-1:0]       chain_sum [MAX_ENTRIES+1];
   logic [IDX_W-1:0]       chain_idx [MAX_ENTRIES+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.wr_en      = accept && (req_data.kind == wrtp_pkg::KIND_WRITE);
      cmd.wr_index   = req_data.entry_index;
      cmd.wr_type    = req_data.entry_type;
      cmd.wr_weight  = req_data.entry_weight;
      cmd.query_type = qtype_ff;
      cmd.tile_count = tile_ff;
      cmd.pass2      = pass2_ff;
   end

   assign chain_tok[0] = '{valid: inject_ff, any: 1'b0, hit: 1'b0};
   assign chain_sum[0] = '0;
   assign chain_idx[0] = '0;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      wrtp_cell #(
         .IDX         (g),
         .MAX_ENTRIES (MAX_ENTRIES),
         .WEIGHT_BITS (WEIGHT_BITS),
         .RANDOM_BITS (RANDOM_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .thr      (thr_ff),
         .prev_tok (chain_tok[g]),
         .prev_sum (chain_sum[g]),
         .prev_idx (chain_idx[g]),
         .cell_tok (chain_tok[g+1]),
         .cell_sum (chain_sum[g+1]),
         .cell_idx (chain_idx[g+1])
      );
   end

   assign rnd_p1 = {1'b0, rnd_ff} + {{RANDOM_BITS{1'b0}}, 1'b1};
   assign prod   = PROD_W'(rnd_p1) * PROD_W'(total_ff);

   always_comb begin
      state_in     = state_ff;
      inject_in    = 1'b0;
      pass2_in     = pass2_ff;
      qtype_in     = qtype_ff;
      rnd_in       = rnd_ff;
      tile_in      = csr_wr_en ? csr_wr_data : tile_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.kind == wrtp_pkg::KIND_PICK)) begin
               qtype_in  = req_data.query_type;
               rnd_in    = req_data.random_value[RANDOM_BITS-1:0];
               inject_in = 1'b1;
               pass2_in  = 1'b0;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            if (chain_tok[MAX_ENTRIES].valid) begin
               total_in = chain_sum[MAX_ENTRIES];
               last_in  = chain_idx[MAX_ENTRIES];
               found_in = chain_tok[MAX_ENTRIES].any;
               pick_in  = chain_tok[MAX_ENTRIES].any ? chain_idx[MAX_ENTRIES] : '0;
               // With no match (not found, index zero) or a zero total (the last match) the answer is known.
               if (chain_tok[MAX_ENTRIES].any && (chain_sum[MAX_ENTRIES] != '0)) begin
                  state_in = ST_SCALE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCALE: begin
            thr_in    = prod[THR_W-1:0];
            inject_in = 1'b1;
            pass2_in  = 1'b1;
            state_in  = ST_PICK;
         end
         ST_PICK: begin
            if (chain_tok[MAX_ENTRIES].valid) begin
               pick_in  = chain_tok[MAX_ENTRIES].hit ? chain_idx[MAX_ENTRIES] : last_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = found_ff;
               rsp_data_in.picked_index = wrtp_pkg::INDEX_BITS'(pick_ff);
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inject_ff    <= 1'b0;
         pass2_ff     <= 1'b0;
         tile_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= inject_in;
         pass2_ff     <= pass2_in;
         tile_ff      <= tile_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qtype_ff    <= qtype_in;
      rnd_ff      <= rnd_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      thr_ff      <= thr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_token_only_in_pass: assert property (@(posedge clock) disable iff (reset)
      chain_tok[MAX_ENTRIES].valid |-> (state_ff == ST_SUM || state_ff == ST_PICK))
      else $error("token left the chain outside a pass");

   a_second_pass_hits: assert property (@(posedge clock) disable iff (reset)
      (chain_tok[MAX_ENTRIES].valid && state_ff == ST_PICK) |-> chain_tok[MAX_ENTRIES].hit)
      else $error("second pass ended without selecting an entry");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.picked_index == '0))
      else $error("not-found result carries a nonzero index");

   a_pick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == wrtp_pkg::KIND_PICK) |=> (inject_ff && state_ff == ST_SUM))
      else $error("accepted pick did not start the sum pass");
`endif

endmodule

// ===== src/wrtp_cell.sv =====
// One cell of the pick chain: holds one table entry and one token stage.
// Depends on wrtp_pkg for the command and token structs.
module wrtp_cell #(
   parameter int unsigned IDX         = 0,
   parameter int unsigned MAX_ENTRIES = wrtp_pkg::MAX_ENTRIES,
   parameter int unsigned WEIGHT_BITS = wrtp_pkg::WEIGHT_BITS,
   parameter int unsigned RANDOM_BITS = wrtp_pkg::RANDOM_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wrtp_pkg::wrtp_cmd_type          cmd,
   input  logic [WEIGHT_BITS+$clog2(MAX_ENTRIES)+RANDOM_BITS-1:0] thr,
   input  wrtp_pkg::wrtp_tok_type          prev_tok,
   input  logic [WEIGHT_BITS+$clog2(MAX_ENTRIES)-1:0] prev_sum,
   input  logic [$clog2(MAX_ENTRIES)-1:0]  prev_idx,
   output wrtp_pkg::wrtp_tok_type          cell_tok,
   output logic [WEIGHT_BITS+$clog2(MAX_ENTRIES)-1:0] cell_sum,
   output logic [$clog2(MAX_ENTRIES)-1:0]  cell_idx
);

   localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
   localparam int unsigned SUM_W = WEIGHT_BITS + IDX_W;
   localparam int unsigned THR_W = SUM_W + RANDOM_BITS;

   logic [wrtp_pkg::TYPE_BITS-1:0] type_ff, type_in;
   logic [WEIGHT_BITS-1:0]         weight_ff, weight_in;
   wrtp_pkg::wrtp_tok_type         tok_ff, tok_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;

   logic             wr_hit;
   logic             active;
   logic             match;
   logic             take;
   logic [SUM_W-1:0] sum_add;
   logic [THR_W-1:0] scaled;

   always_comb begin
      wr_hit    = cmd.wr_en && (32'(cmd.wr_index) == 32'(IDX));
      type_in   = wr_hit ? cmd.wr_type : type_ff;
      weight_in = wr_hit ? WEIGHT_BITS'(cmd.wr_weight) : weight_ff;

      active  = 32'(cmd.tile_count) > 32'(IDX);
      match   = prev_tok.valid && active && (type_ff == cmd.query_type) && !prev_tok.hit;
      sum_add = match ? (prev_sum + SUM_W'(weight_ff)) : prev_sum;
      // floor(sum * 2^R / total) > r holds exactly when sum * 2^R >= (r + 1) * total.
      scaled  = {sum_add, {RANDOM_BITS{1'b0}}};
      take    = cmd.pass2 ? (match && (scaled >= thr)) : match;

      tok_in.valid = prev_tok.valid;
      tok_in.any   = prev_tok.any | match;
      tok_in.hit   = prev_tok.hit | (cmd.pass2 && take);
      sum_in       = sum_add;
      idx_in       = take ? IDX_W'(IDX) : prev_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff      <= '0;
         weight_ff    <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         type_ff      <= type_in;
         weight_ff    <= weight_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.any <= tok_in.any;
      tok_ff.hit <= tok_in.hit;
      sum_ff     <= sum_in;
      idx_ff     <= idx_in;
   end

   assign cell_tok = tok_ff;
   assign cell_sum = sum_ff;
   assign cell_idx = idx_ff;

endmodule

// ===== bench/weighted_random_tile_pick_tb.sv =====
// Self-checking testbench for weighted_random_tile_pick: directed and random table writes, tile
// count writes and picks, mostly under random valid and stall; a scoreboard predicts every pick.
// Depends on wrtp_pkg and the weighted_random_tile_pick RTL.
module weighted_random_tile_pick_tb;

   localparam int unsigned SETTLE_CYCLES = 2 * wrtp_pkg::MAX_ENTRIES + 8;
   localparam int unsigned SEGMENT_ITEMS = 58;
   localparam int unsigned REQ_BITS      = $bits(wrtp_pkg::wrtp_req_type);

   // Keeps a copy of the tile table and predicts the result of every accepted pick.
   class tile_pick_checker;
      logic [wrtp_pkg::TYPE_BITS-1:0]         type_tab[wrtp_pkg::MAX_ENTRIES];
      logic [wrtp_pkg::FIELD_WEIGHT_BITS-1:0] weight_tab[wrtp_pkg::MAX_ENTRIES];
      logic [wrtp_pkg::CNT_BITS-1:0]          tile_count;
      wrtp_pkg::wrtp_rsp_type                 expected_picks[$];
      int unsigned                            errors;

      function new();
         for (int i = 0; i < wrtp_pkg::MAX_ENTRIES; i++) begin
            type_tab[i]   = '0;
            weight_tab[i] = '0;
         end
         tile_count = '0;
         errors     = 0;
      endfunction

      function void set_count(logic [wrtp_pkg::CNT_BITS-1:0] value);
         tile_count = value;
      endfunction

      function int unsigned pending();
         return expected_picks.size();
      endfunction

      function void log_request(wrtp_pkg::wrtp_req_type req);
         int unsigned            in_use;
         int unsigned            last;
         bit                     any;
         longint unsigned        total;
         longint unsigned        run;
         longint unsigned        scaled;
         wrtp_pkg::wrtp_rsp_type rsp;

         if (req.kind == wrtp_pkg::KIND_WRITE) begin
            type_tab[req.entry_index]   = req.entry_type;
            weight_tab[req.entry_index] = req.entry_weight;
            return;
         end
         in_use = (tile_count > wrtp_pkg::MAX_ENTRIES) ? wrtp_pkg::MAX_ENTRIES : tile_count;
         total  = 0;
         any    = 1'b0;
         last   = 0;
         for (int unsigned i = 0; i < in_use; i++) begin
            if (type_tab[i] == req.query_type) begin
               total += weight_tab[i];
               last   = i;
               any    = 1'b1;
            end
         end
         rsp.found        = any;
         rsp.picked_index = '0;
         if (any) begin
            rsp.picked_index = last[wrtp_pkg::INDEX_BITS-1:0];
            // With a zero total the last matching slot stands.
            if (total != 0) begin
               run = 0;
               for (int unsigned i = 0; i < last; i++) begin
                  if (type_tab[i] == req.query_type) begin
                     run   += weight_tab[i];
                     scaled = (run << wrtp_pkg::RANDOM_BITS) / total;
                     if (req.random_value < scaled) begin
                        rsp.picked_index = i[wrtp_pkg::INDEX_BITS-1:0];
                        break;
                     end
                  end
               end
            end
         end
         expected_picks.push_back(rsp);
      endfunction

      function void check_pick(wrtp_pkg::wrtp_rsp_type actual);
         wrtp_pkg::wrtp_rsp_type want;

         if (expected_picks.size() == 0) begin
            $error("result transfer with no pick outstanding: found=%0d picked_index=%0d",
                   actual.found, actual.picked_index);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         if (actual.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, actual.found);
            errors++;
         end
         if (actual.picked_index !== want.picked_index) begin
            $error("picked_index: expected %0d, actual %0d", want.picked_index,
                   actual.picked_index);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   wrtp_pkg::wrtp_req_type        req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   wrtp_pkg::wrtp_rsp_type        rsp_data;
   logic                          csr_wr_en;
   logic [wrtp_pkg::CNT_BITS-1:0] csr_wr_data;

   tile_pick_checker picks = new();
   int unsigned send_idle_pct;
   int unsigned stall_pct;

   weighted_random_tile_pick uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // The receiver decides its stall at every falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         picks.check_pick(rsp_data);
      end
   end

   function automatic wrtp_pkg::wrtp_req_type noise_item();
      wrtp_pkg::wrtp_req_type item;
      item = REQ_BITS'({$urandom, $urandom});
      return item;
   endfunction

   function automatic wrtp_pkg::wrtp_req_type write_item(int unsigned idx, int unsigned typ,
                                                         int unsigned weight);
      wrtp_pkg::wrtp_req_type item;
      item              = noise_item();
      item.kind         = wrtp_pkg::KIND_WRITE;
      item.entry_index  = wrtp_pkg::INDEX_BITS'(idx);
      item.entry_type   = wrtp_pkg::TYPE_BITS'(typ);
      item.entry_weight = wrtp_pkg::FIELD_WEIGHT_BITS'(weight);
      return item;
   endfunction

   function automatic wrtp_pkg::wrtp_req_type pick_item(int unsigned typ, int unsigned r);
      wrtp_pkg::wrtp_req_type item;
      item              = noise_item();
      item.kind         = wrtp_pkg::KIND_PICK;
      item.query_type   = wrtp_pkg::TYPE_BITS'(typ);
      item.random_value = wrtp_pkg::FIELD_RANDOM_BITS'(r);
      return item;
   endfunction

   // Most traffic uses a few types so that picks find several matching slots.
   function automatic int unsigned some_type();
      return ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(15);
   endfunction

   function automatic wrtp_pkg::wrtp_req_type random_item();
      int unsigned  roll;
      int unsigned  weight;
      int unsigned  r;
      roll   = $urandom_range(99);
      weight = $urandom_range(255);
      r      = $urandom_range(65535);
      if (roll < 10) weight = 0;
      else if (roll < 20) weight = 255;
      if (roll > 94) r = 0;
      else if (roll > 89) r = 65535;
      if ($urandom_range(99) < 45) begin
         return write_item($urandom_range(15), some_type(), weight);
      end else begin
         return pick_item(some_type(), r);
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
   task automatic send(wrtp_pkg::wrtp_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
         @(negedge clock);
      end
      picks.log_request(item);
      @(negedge clock);
   endtask

   // Lowers valid and waits until every pick has returned and the block has settled.
   task automatic drain();
      req_valid = 1'b0;
      while (picks.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(int unsigned value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = wrtp_pkg::CNT_BITS'(value);
      picks.set_count(wrtp_pkg::CNT_BITS'(value));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 8;
      stall_pct     = 73;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table after reset: nothing can match.
      send(pick_item(0, 12345));
      write_count(4);
      send(write_item(0, 3, 255));
      send(write_item(1, 3, 0));
      send(write_item(2, 5, 0));
      send(write_item(3, 3, 1));
      // Slot beyond the count is stored but stays out of picks for now.
      send(write_item(12, 9, 10));
      send(pick_item(3, 0));
      send(pick_item(3, 65535));
      send(pick_item(5, 777));
      send(pick_item(9, 100));
      send(pick_item(15, 40000));
      // A count above the table size saturates.
      write_count(20);
      send(pick_item(9, 65535));
      send(pick_item(0, 0));
      send(write_item(15, 15, 255));
      send(pick_item(15, 65535));
      write_count(31);
      send(pick_item(3, 65279));
      send(pick_item(3, 65280));

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 8;
               stall_pct     = 73;
            end
            1: begin
               send_idle_pct = 73;
               stall_pct     = 8;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            case (seg)
               0: write_count(wrtp_pkg::MAX_ENTRIES);
               1: write_count($urandom_range(1, 15));
               2: write_count($urandom_range(17, 31));
               default: write_count(mode == 0 ? 0 : (mode == 1 ? 1 : 31));
            endcase
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
               if ($urandom_range(99) < 2) begin
                  drain();
               end
               send(random_item());
            end
         end
      end

      drain();
      if (picks.errors == 0 && picks.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
